### src/cvrs_pkg.sv
`timescale 1ns / 1ps

package cvrs_pkg;

  localparam int unsigned START_W    = 48;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned CAP_W      = 48;
  localparam int unsigned BOFF_W     = 32;
  localparam int unsigned SEG_IDX_W  = 2;
  localparam int unsigned SEG_CNT_W  = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned S_TDATA_W  = 80;
  localparam int unsigned M_TDATA_W  = 120;
  localparam int unsigned M_USED_W   = SEG_IDX_W + CAP_W + COUNT_W + BOFF_W;
  localparam int unsigned SECTOR_SHIFT = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_CAP0  = 3'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEEK,
    ST_LOAD,
    ST_ADV
  } cvrs_state_e;

  typedef struct packed {
    logic load_in;
    logic seek;
    logic load_out;
    logic advance;
  } cvrs_cmd_t;

  typedef struct packed {
    logic seek_found;
    logic seek_fail;
    logic out_busy;
    logic last;
  } cvrs_sts_t;

endpackage

### src/cvrs_ctrl.sv
`timescale 1ns / 1ps

module cvrs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_beat_i,
  input  cvrs_pkg::cvrs_sts_t sts_i,
  output logic                in_ready_o,
  output cvrs_pkg::cvrs_cmd_t cmd_o
);

  cvrs_pkg::cvrs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cvrs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      cvrs_pkg::ST_IDLE: begin
        if (in_beat_i) state_d = cvrs_pkg::ST_SEEK;
      end
      cvrs_pkg::ST_SEEK: begin
        if (sts_i.seek_found || sts_i.seek_fail) state_d = cvrs_pkg::ST_LOAD;
      end
      cvrs_pkg::ST_LOAD: begin
        if (!sts_i.out_busy) begin
          state_d = sts_i.last ? cvrs_pkg::ST_IDLE : cvrs_pkg::ST_ADV;
        end
      end
      cvrs_pkg::ST_ADV: state_d = cvrs_pkg::ST_LOAD;
      default: state_d = cvrs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      cvrs_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_beat_i;
      end
      cvrs_pkg::ST_SEEK: cmd_o.seek     = 1'b1;
      cvrs_pkg::ST_LOAD: cmd_o.load_out = !sts_i.out_busy;
      cvrs_pkg::ST_ADV:  cmd_o.advance  = 1'b1;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### src/cvrs_dp.sv
`timescale 1ns / 1ps

module cvrs_dp #(
  parameter int unsigned MAX_SEGMENTS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cvrs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cvrs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [cvrs_pkg::START_W-1:0]        start_sector_i,
  input  logic [cvrs_pkg::COUNT_W-1:0]        sector_count_i,
  input  cvrs_pkg::cvrs_cmd_t                 cmd_i,
  output cvrs_pkg::cvrs_sts_t                 sts_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [cvrs_pkg::SEG_IDX_W-1:0]      out_index_o,
  output logic [cvrs_pkg::CAP_W-1:0]          out_offset_o,
  output logic [cvrs_pkg::COUNT_W-1:0]        out_sectors_o,
  output logic [cvrs_pkg::BOFF_W-1:0]         out_boff_o,
  output logic                                out_last_o,
  output logic                                out_err_o
);

  localparam int unsigned IdxW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned NsegW = IdxW + 1;
  localparam logic [NsegW-1:0] MaxSeg = NsegW'(MAX_SEGMENTS);
  localparam int unsigned PadW = cvrs_pkg::CAP_W - cvrs_pkg::COUNT_W;

  logic [cvrs_pkg::SEG_CNT_W-1:0] seg_count_q;
  logic [cvrs_pkg::CAP_W-1:0]     cap_q [MAX_SEGMENTS];

  logic [NsegW-1:0]               idx_q;
  logic [cvrs_pkg::CAP_W-1:0]     off_q;
  logic [cvrs_pkg::COUNT_W-1:0]   left_q;
  logic [cvrs_pkg::COUNT_W-1:0]   piece_q;
  logic [cvrs_pkg::BOFF_W-1:0]    boff_q;
  logic                           err_q;

  logic                           out_valid_q;
  logic [cvrs_pkg::SEG_IDX_W-1:0] out_index_q;
  logic [cvrs_pkg::CAP_W-1:0]     out_offset_q;
  logic [cvrs_pkg::COUNT_W-1:0]   out_sectors_q;
  logic [cvrs_pkg::BOFF_W-1:0]    out_boff_q;
  logic                           out_last_q;
  logic                           out_err_q;

  logic [NsegW-1:0]               nseg;
  logic [NsegW-1:0]               idx_nxt;
  logic [cvrs_pkg::CAP_W-1:0]     cap_cur;
  logic [cvrs_pkg::CAP_W-1:0]     cap_nxt;
  logic [cvrs_pkg::CAP_W-1:0]     room;
  logic [cvrs_pkg::COUNT_W-1:0]   seek_piece;
  logic [cvrs_pkg::COUNT_W-1:0]   adv_piece;
  logic                           fail;
  logic                           found;
  logic                           last;

  // active segments, clamped to 1..MAX_SEGMENTS
  always_comb begin
    if (seg_count_q == '0) begin
      nseg = NsegW'(1);
    end else if (seg_count_q > cvrs_pkg::SEG_CNT_W'(MAX_SEGMENTS)) begin
      nseg = MaxSeg;
    end else begin
      nseg = NsegW'(seg_count_q);
    end
  end

  assign idx_nxt    = idx_q + NsegW'(1);
  assign cap_cur    = cap_q[idx_q[IdxW-1:0]];
  assign cap_nxt    = cap_q[idx_nxt[IdxW-1:0]];
  assign fail       = idx_q >= nseg;
  assign found      = !fail && (off_q < cap_cur);
  assign room       = cap_cur - off_q;
  assign seek_piece = ({{PadW{1'b0}}, left_q} >= room) ? room[cvrs_pkg::COUNT_W-1:0] : left_q;
  assign adv_piece  = ({{PadW{1'b0}}, left_q} >= cap_nxt) ?
                      cap_nxt[cvrs_pkg::COUNT_W-1:0] : left_q;
  assign last       = err_q || (left_q == piece_q) || (idx_nxt >= nseg);

  assign sts_o.seek_found = found;
  assign sts_o.seek_fail  = fail;
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;
  assign sts_o.last       = last;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q <= cvrs_pkg::SEG_CNT_W'(1);
      for (int i = 0; i < MAX_SEGMENTS; i++) cap_q[i] <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == cvrs_pkg::CFG_SEG_COUNT) begin
        seg_count_q <= cfg_data_i[cvrs_pkg::SEG_CNT_W-1:0];
      end
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
        if (cfg_index_i == cvrs_pkg::CFG_SEG_CAP0 + cvrs_pkg::CFG_IDX_W'(i)) begin
          cap_q[i] <= cfg_data_i[cvrs_pkg::CAP_W-1:0];
        end
      end
    end
  end

  // walk state
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      idx_q  <= '0;
      off_q  <= start_sector_i;
      left_q <= sector_count_i;
      boff_q <= '0;
      err_q  <= 1'b0;
    end else if (cmd_i.seek) begin
      if (fail) begin
        err_q <= 1'b1;
      end else if (found) begin
        piece_q <= seek_piece;
      end else begin
        off_q <= off_q - cap_cur;
        idx_q <= idx_nxt;
      end
    end else if (cmd_i.load_out) begin
      left_q <= left_q - piece_q;
    end else if (cmd_i.advance) begin
      idx_q   <= idx_nxt;
      off_q   <= '0;
      boff_q  <= boff_q + {piece_q[cvrs_pkg::BOFF_W-cvrs_pkg::SECTOR_SHIFT-1:0],
                           {cvrs_pkg::SECTOR_SHIFT{1'b0}}};
      piece_q <= adv_piece;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_index_q   <= err_q && fail ? '0 : cvrs_pkg::SEG_IDX_W'(idx_q);
      out_offset_q  <= err_q && fail ? '0 : off_q;
      out_sectors_q <= err_q && fail ? '0 : piece_q;
      out_boff_q    <= err_q && fail ? '0 : boff_q;
      out_last_q    <= last;
      out_err_q     <= err_q || ((left_q != piece_q) && (idx_nxt >= nseg));
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_index_o   = out_index_q;
  assign out_offset_o  = out_offset_q;
  assign out_sectors_o = out_sectors_q;
  assign out_boff_o    = out_boff_q;
  assign out_last_o    = out_last_q;
  assign out_err_o     = out_err_q;

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending beat");

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q) |-> out_last_q)
    else $error("range error on a non-final beat");

  a_seek_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.seek |-> (idx_q <= nseg))
    else $error("segment walk past the active segments");

  a_adv_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance |-> (idx_nxt < nseg))
    else $error("advance beyond the last segment");

endmodule

### src/concat_volume_request_splitter.sv
// an accepted request goes through SEEK, which steps past segments until it finds its
//   segment or runs out, then LOAD, which registers the first beat once the output is not stalled
// one request in flight at a time: a new request is taken only when idle; each later
//   piece is made in ADV, then registered in LOAD, which again waits on a stalled output
// reset: asynchronous active low; segment_count returns to 1, capacities to 0,
//   output beat and walk controller are cleared
`timescale 1ns / 1ps

module concat_volume_request_splitter #(
  parameter int unsigned MAX_SEGMENTS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cvrs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cvrs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // start_sector [47:0], sector_count [79:48]
  input  logic [cvrs_pkg::S_TDATA_W-1:0]      s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // segment_index [1:0], segment_offset [49:2], piece_sectors [81:50],
  // buffer_byte_offset [113:82], zero [119:114]
  output logic [cvrs_pkg::M_TDATA_W-1:0]      m_axis_tdata_o,
  output logic                                m_axis_tlast_o,
  // range_error [0]
  output logic                                m_axis_tuser_o
);

  cvrs_pkg::cvrs_cmd_t            cmd;
  cvrs_pkg::cvrs_sts_t            sts;
  logic                           in_ready;
  logic [cvrs_pkg::SEG_IDX_W-1:0] out_index;
  logic [cvrs_pkg::CAP_W-1:0]     out_offset;
  logic [cvrs_pkg::COUNT_W-1:0]   out_sectors;
  logic [cvrs_pkg::BOFF_W-1:0]    out_boff;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = in_ready;

  cvrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_beat_i  (s_axis_tvalid_i && in_ready),
    .sts_i      (sts),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  cvrs_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .start_sector_i (s_axis_tdata_i[cvrs_pkg::START_W-1:0]),
    .sector_count_i (s_axis_tdata_i[cvrs_pkg::START_W +: cvrs_pkg::COUNT_W]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .out_index_o    (out_index),
    .out_offset_o   (out_offset),
    .out_sectors_o  (out_sectors),
    .out_boff_o     (out_boff),
    .out_last_o     (m_axis_tlast_o),
    .out_err_o      (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {{(cvrs_pkg::M_TDATA_W - cvrs_pkg::M_USED_W){1'b0}},
                           out_boff, out_sectors, out_offset, out_index};

endmodule
